// ----- rtl/fmr_pkg.sv -----
// shared types and constants of the framed message receiver
package fmr_pkg;

    localparam int CHUNK_SIZE_DEF = 256;

    localparam logic [7:0]  MAGIC_RST   = 8'h00;
    localparam logic [7:0]  ACK_TYPE_RST = 8'h00;
    localparam logic [15:0] BUF_LEN_RST = 16'hFFFF;

    // register indexes on the configuration port
    localparam logic [1:0] REG_MAGIC    = 2'd0;
    localparam logic [1:0] REG_ACK_TYPE = 2'd1;
    localparam logic [1:0] REG_BUF_LEN  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_TX    = 2'd0;
    localparam logic [1:0] KIND_STORE = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    // work left by one received byte
    typedef struct packed {
        logic        has_store;
        logic        has_ack;
        logic        has_done;
        logic [15:0] offset;
        logic [7:0]  sbyte;
        logic [7:0]  mtype;
        logic [15:0] mlen;
        logic        status;
    } t_cmd;

    // one result beat
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx;
        logic [15:0] offset;
        logic [7:0]  sbyte;
        logic [7:0]  mtype;
        logic [15:0] mlen;
        logic        status;
        logic        last;
    } t_beat;

endpackage

// ----- rtl/fmr_front.sv -----
// header parser and body tracker: turns each received byte that leaves work into a command
module fmr_front import fmr_pkg::*; #(
    parameter int CHUNK_SIZE = CHUNK_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_byte,
    input  logic [7:0]  i_magic,
    input  logic [15:0] i_buf_len,
    output logic        o_push,
    output t_cmd        o_cmd
);

    localparam int CW = $clog2(CHUNK_SIZE + 1);

    typedef enum logic [2:0] {
        PH_HUNT, PH_TYPE, PH_LEN_LO, PH_LEN_HI, PH_BODY
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_type, n_type;
    logic [15:0] r_len, n_len;
    logic [15:0] r_off, n_off;
    logic [CW-1:0] r_cc, n_cc;

    logic [15:0]   off_inc;
    logic [CW-1:0] cc_inc;
    logic [15:0]   full_len;
    logic          body_done;

    assign off_inc   = r_off + 16'd1;
    assign cc_inc    = r_cc + CW'(1);
    assign full_len  = {i_byte, r_len[7:0]};
    assign body_done = (off_inc == r_len);

    always_comb begin
        n_phase = r_phase;
        n_type  = r_type;
        n_len   = r_len;
        n_off   = r_off;
        n_cc    = r_cc;
        o_cmd   = '0;
        o_cmd.mtype = r_type;
        case (r_phase)
            PH_HUNT: begin
                if (i_byte == i_magic) n_phase = PH_TYPE;
            end
            PH_TYPE: begin
                n_type  = i_byte;
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_len   = {8'd0, i_byte};
                n_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_len         = full_len;
                n_off         = '0;
                n_cc          = '0;
                o_cmd.has_ack = 1'b1;
                o_cmd.mlen    = full_len;
                o_cmd.status  = (full_len > i_buf_len);
                if (full_len == 16'd0) begin
                    o_cmd.has_done = 1'b1;
                    n_phase        = PH_HUNT;
                end else begin
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                o_cmd.has_store = (r_off < i_buf_len);
                o_cmd.offset    = r_off;
                o_cmd.sbyte     = i_byte;
                o_cmd.mlen      = r_len;
                o_cmd.status    = (r_len > i_buf_len);
                n_off           = off_inc;
                n_cc            = cc_inc;
                if (cc_inc == CW'(CHUNK_SIZE) || body_done) begin
                    n_cc          = '0;
                    o_cmd.has_ack = 1'b1;
                end
                if (body_done) begin
                    o_cmd.has_done = 1'b1;
                    n_off          = '0;
                    n_cc           = '0;
                    n_phase        = PH_HUNT;
                end
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
        if (!o_cmd.has_store) begin
            o_cmd.offset = '0;
            o_cmd.sbyte  = '0;
        end
        if (!o_cmd.has_done) begin
            o_cmd.mtype  = '0;
            o_cmd.mlen   = '0;
            o_cmd.status = 1'b0;
        end
    end

    assign o_push = i_accept && (o_cmd.has_store || o_cmd.has_ack || o_cmd.has_done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_type  <= '0;
            r_len   <= '0;
            r_off   <= '0;
            r_cc    <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_type  <= n_type;
            r_len   <= n_len;
            r_off   <= n_off;
            r_cc    <= n_cc;
        end
    end

endmodule

// ----- rtl/fmr_queue.sv -----
// two-entry command queue between parser and result sequencer
module fmr_queue import fmr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty,
    output logic o_full
);

    t_cmd       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    assign o_cmd   = r_mem[r_rd];
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop)  r_rd <= ~r_rd;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- rtl/fmr_back.sv -----
// result sequencer: expands a command into store, ack and done beats
module fmr_back import fmr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic       i_cmd_valid,
    output logic       o_pop,
    input  logic [7:0] i_magic,
    input  logic [7:0] i_ack_type,
    output logic       o_valid,
    input  logic       i_ready,
    output t_beat      o_beat
);

    typedef enum logic [2:0] {
        ST_STORE, ST_ACK0, ST_ACK1, ST_ACK2, ST_ACK3, ST_DONE
    } t_step;

    t_step r_step;
    logic  r_started;
    logic  r_valid;
    t_beat r_beat;

    t_step start_step, cur_step, nxt_step;
    logic  at_end;
    logic  load;
    t_beat beat;

    always_comb begin
        if (i_cmd.has_store)    start_step = ST_STORE;
        else if (i_cmd.has_ack) start_step = ST_ACK0;
        else                    start_step = ST_DONE;
        cur_step = r_started ? r_step : start_step;

        nxt_step = ST_DONE;
        at_end   = 1'b0;
        case (cur_step)
            ST_STORE: begin
                if (i_cmd.has_ack)       nxt_step = ST_ACK0;
                else if (i_cmd.has_done) nxt_step = ST_DONE;
                else                     at_end   = 1'b1;
            end
            ST_ACK0: nxt_step = ST_ACK1;
            ST_ACK1: nxt_step = ST_ACK2;
            ST_ACK2: nxt_step = ST_ACK3;
            ST_ACK3: begin
                if (i_cmd.has_done) nxt_step = ST_DONE;
                else                at_end   = 1'b1;
            end
            default: at_end = 1'b1;
        endcase

        beat      = '0;
        beat.last = at_end;
        case (cur_step)
            ST_STORE: begin
                beat.kind   = KIND_STORE;
                beat.offset = i_cmd.offset;
                beat.sbyte  = i_cmd.sbyte;
            end
            ST_ACK0: begin
                beat.kind = KIND_TX;
                beat.tx   = i_magic;
            end
            ST_ACK1: begin
                beat.kind = KIND_TX;
                beat.tx   = i_ack_type;
            end
            ST_ACK2, ST_ACK3: begin
                beat.kind = KIND_TX;
            end
            default: begin
                beat.kind   = KIND_DONE;
                beat.mtype  = i_cmd.mtype;
                beat.mlen   = i_cmd.mlen;
                beat.status = i_cmd.status;
            end
        endcase
    end

    assign load  = i_cmd_valid && (!r_valid || i_ready);
    assign o_pop = load && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= ST_STORE;
            r_started <= 1'b0;
            r_valid   <= 1'b0;
        end else if (load) begin
            r_valid   <= 1'b1;
            r_started <= !at_end;
            r_step    <= nxt_step;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_beat <= beat;
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

// ----- rtl/framed_message_receiver.sv -----
// framed message receiver: header hunt, chunk acks, payload store beats, frame done beats
// the first result beat of a byte passes the command queue, then the output register
// throughput: one result beat per cycle while m_tready is high; a byte causes 0 to 6 beats;
//   bytes with no beats push no command and pass each cycle while the queue has a free slot
// the two-entry command queue lets bytes enter while earlier beats still drain
// reset: synchronous, active low; parser hunts, queue and output empty, registers to defaults
module framed_message_receiver import fmr_pkg::*; #(
    parameter int CHUNK_SIZE = CHUNK_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // received byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] tx_byte, [23:8] store_offset, [31:24] store_byte, [39:32] message_type,
    // [55:40] message_length, [56] status, [63:57] zero
    output logic [63:0] m_tdata,
    output logic [1:0]  m_tuser,   // [1:0] result_kind
    output logic        m_tlast,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration registers
    logic [7:0]  r_magic;
    logic [7:0]  r_ack_type;
    logic [15:0] r_buf_len;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic    <= MAGIC_RST;
            r_ack_type <= ACK_TYPE_RST;
            r_buf_len  <= BUF_LEN_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_MAGIC:    r_magic    <= pwdata[7:0];
                REG_ACK_TYPE: r_ack_type <= pwdata[7:0];
                REG_BUF_LEN:  r_buf_len  <= pwdata[15:0];
                default:      ;  // unmapped address, write dropped
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MAGIC:    prdata = {24'd0, r_magic};
            REG_ACK_TYPE: prdata = {24'd0, r_ack_type};
            REG_BUF_LEN:  prdata = {16'd0, r_buf_len};
            default:      prdata = '0;
        endcase
    end

    // front: parse bytes into commands
    logic q_push, q_pop, q_empty, q_full;
    t_cmd f_cmd, q_cmd;
    logic in_beat;

    // take a byte whenever the queue has a free slot
    assign s_tready = !q_full;
    assign in_beat  = s_tvalid && s_tready;

    fmr_front #(
        .CHUNK_SIZE (CHUNK_SIZE)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_beat),
        .i_byte    (s_tdata),
        .i_magic   (r_magic),
        .i_buf_len (r_buf_len),
        .o_push    (q_push),
        .o_cmd     (f_cmd)
    );

    fmr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // back: expand each command into result beats
    t_beat out_beat;

    fmr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_cmd_valid (!q_empty),
        .o_pop       (q_pop),
        .i_magic     (r_magic),
        .i_ack_type  (r_ack_type),
        .o_valid     (m_tvalid),
        .i_ready     (m_tready),
        .o_beat      (out_beat)
    );

    assign m_tdata = {7'd0, out_beat.status, out_beat.mlen, out_beat.mtype,
                      out_beat.sbyte, out_beat.offset, out_beat.tx};
    assign m_tuser = out_beat.kind;
    assign m_tlast = out_beat.last;

    // a done beat always closes the beats of its byte
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser == KIND_DONE) |-> m_tlast)
        else $error("done beat without tlast");

    // the queue is never written while full
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("command queue overflow");

    // the queue is never read while empty
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("command queue underflow");

    // an overflow status needs a nonzero length
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser == KIND_DONE && m_tdata[56]) |-> (m_tdata[55:40] != 16'd0))
        else $error("overflow status on empty message");

endmodule

// ----- bench/tb_framed_message_receiver.sv -----
// self-checking testbench of the framed message receiver
module tb_framed_message_receiver;
    import fmr_pkg::*;

    // parser position inside a frame
    typedef enum logic [2:0] {
        PH_HUNT,
        PH_TYPE,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_BODY
    } t_parse_phase;

    // index just past the register map, a write there must change nothing
    localparam logic [1:0]  REG_UNUSED   = 2'd3;
    localparam logic [15:0] CHUNK_BYTES  = 16'(CHUNK_SIZE_DEF);
    localparam int          BYTE_TARGET  = 370;  // payload and header bytes to send
    localparam int          CALM_AFTER   = 330;  // no idling once this many are in
    localparam int          HOLD_CYCLES  = 400;  // long receiver hold-off
    localparam int          SETTLE       = 8;    // settle time at the end of a drain

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [3:0]  paddr     = 4'h0;
    logic [31:0] pwdata    = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    framed_message_receiver i_dut (.*);

    // period of 2
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor state: register copies and the frame parser
    // ------------------------------------------------------------------
    logic [7:0]   cfg_magic    = MAGIC_RST;
    logic [7:0]   cfg_ack_type = ACK_TYPE_RST;
    logic [15:0]  cfg_buf_len  = BUF_LEN_RST;

    t_parse_phase parse_phase  = PH_HUNT;
    logic [7:0]   held_type    = 8'h00;
    logic [15:0]  held_length  = 16'h0000;
    logic [15:0]  byte_offset  = 16'h0000;
    logic [15:0]  chunk_count  = 16'h0000;

    t_beat beats_due[$];      // result beats still to come, oldest first
    int    burst_len;         // beats caused by the byte being predicted

    // run bookkeeping
    int  bytes_taken    = 0;
    int  bytes_ignored  = 0;
    int  beats_checked  = 0;
    int  frames_done    = 0;
    int  frames_over    = 0;
    int  input_stalls   = 0;
    int  mismatches     = 0;

    // idling control
    logic idle_on       = 1'b1;
    logic rx_hold       = 1'b0;
    int   rx_stall_left = 0;

    function automatic void add_beat(input logic [1:0] kind, input logic [7:0] tx,
                                     input logic [15:0] off, input logic [7:0] sb,
                                     input logic [7:0] mt, input logic [15:0] ml,
                                     input logic st);
        t_beat b;
        b.kind   = kind;
        b.tx     = tx;
        b.offset = off;
        b.sbyte  = sb;
        b.mtype  = mt;
        b.mlen   = ml;
        b.status = st;
        b.last   = 1'b0;
        beats_due.push_back(b);
        burst_len++;
    endfunction

    // four-byte ack header: magic, ack type, two zero bytes
    function automatic void add_ack();
        add_beat(KIND_TX, cfg_magic, 16'h0, 8'h0, 8'h0, 16'h0, 1'b0);
        add_beat(KIND_TX, cfg_ack_type, 16'h0, 8'h0, 8'h0, 16'h0, 1'b0);
        add_beat(KIND_TX, 8'h00, 16'h0, 8'h0, 8'h0, 16'h0, 1'b0);
        add_beat(KIND_TX, 8'h00, 16'h0, 8'h0, 8'h0, 16'h0, 1'b0);
    endfunction

    // frame end: status uses the buffer length as it stands now
    function automatic void add_done();
        logic over;
        over = (held_length > cfg_buf_len);
        add_beat(KIND_DONE, 8'h0, 16'h0, 8'h0, held_type, held_length, over);
        frames_done++;
        if (over) frames_over++;
        parse_phase = PH_HUNT;
        byte_offset = 16'h0000;
        chunk_count = 16'h0000;
    endfunction

    // advance the parser by one received byte and queue the beats it causes
    function automatic void predict_rx_byte(input logic [7:0] b);
        logic  finished;
        t_beat tail;
        burst_len = 0;
        case (parse_phase)
            PH_HUNT: begin
                if (b == cfg_magic) parse_phase = PH_TYPE;
                else bytes_ignored++;
            end
            PH_TYPE: begin
                held_type   = b;
                parse_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                held_length = {8'h00, b};
                parse_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                held_length[15:8] = b;
                byte_offset = 16'h0000;
                chunk_count = 16'h0000;
                parse_phase = PH_BODY;
                add_ack();
                if (held_length == 16'h0000) add_done();
            end
            default: begin
                // bytes past the buffer are dropped but still counted
                if (byte_offset < cfg_buf_len)
                    add_beat(KIND_STORE, 8'h0, byte_offset, b, 8'h0, 16'h0, 1'b0);
                byte_offset = byte_offset + 16'd1;
                chunk_count = chunk_count + 16'd1;
                finished = (byte_offset == held_length);
                if (chunk_count == CHUNK_BYTES || finished) begin
                    chunk_count = 16'h0000;
                    add_ack();
                end
                if (finished) add_done();
            end
        endcase
        // last beat of this byte carries tlast
        if (burst_len > 0) begin
            tail = beats_due.pop_back();
            tail.last = 1'b1;
            beats_due.push_back(tail);
        end
    endfunction

    function automatic string fmt_beat(input t_beat b);
        return $sformatf("kind=%0d tx=%h off=%h sb=%h mt=%h ml=%h st=%b last=%b",
                         b.kind, b.tx, b.offset, b.sbyte, b.mtype, b.mlen, b.status,
                         b.last);
    endfunction

    function automatic void note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10) $display("mismatch: %0s", what);
    endfunction

    // ------------------------------------------------------------------
    // input monitor: every accepted byte goes through the predictor
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && s_tvalid && s_tready) begin
            bytes_taken++;
            predict_rx_byte(s_tdata);
        end
        if (i_rst_n && s_tvalid && !s_tready) input_stalls++;
    end

    // ------------------------------------------------------------------
    // result checker: each accepted beat against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_beat got;
        t_beat want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.kind   = m_tuser;
            got.tx     = m_tdata[7:0];
            got.offset = m_tdata[23:8];
            got.sbyte  = m_tdata[31:24];
            got.mtype  = m_tdata[39:32];
            got.mlen   = m_tdata[55:40];
            got.status = m_tdata[56];
            got.last   = m_tlast;
            beats_checked++;
            if (beats_due.size() == 0) begin
                note_mismatch({"beat with nothing expected: ", fmt_beat(got)});
            end else begin
                want = beats_due.pop_front();
                if (got !== want)
                    note_mismatch({"expected ", fmt_beat(want), " got ", fmt_beat(got)});
            end
        end
    end

    // ------------------------------------------------------------------
    // result side readiness: random stall bursts,
    // or held low for the whole long hold-off
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rx_hold) begin
            m_tready <= 1'b0;
        end else if (rx_stall_left != 0) begin
            m_tready <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
        end else if (idle_on && $urandom_range(7, 0) == 0) begin
            m_tready <= 1'b0;
            rx_stall_left <= $urandom_range(13, 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // shared driving tasks, all entered and left at a rising edge
    // ------------------------------------------------------------------

    // offer one byte and wait for it to be taken
    task automatic send_byte(input logic [7:0] b);
        if (idle_on && $urandom_range(3, 0) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(14, 1)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    // header with the current magic, then a random body
    task automatic send_frame(input logic [7:0] mtype, input logic [15:0] len);
        send_byte(cfg_magic);
        send_byte(mtype);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        for (int i = 0; i < len; i++) send_byte(8'($urandom_range(255, 0)));
    endtask

    // stop offering, let every expected beat arrive, then let the pipe settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (beats_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // apb write with setup and access cycles, then read back the register unless it is unmapped
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            REG_MAGIC:    cfg_magic    = value[7:0];
            REG_ACK_TYPE: cfg_ack_type = value[7:0];
            REG_BUF_LEN:  cfg_buf_len  = value[15:0];
            default: ;
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_UNUSED) begin
            psel <= 1'b0;
        end else begin
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            case (idx)
                REG_MAGIC:    readback = {24'h0, cfg_magic};
                REG_ACK_TYPE: readback = {24'h0, cfg_ack_type};
                default:      readback = {16'h0, cfg_buf_len};
            endcase
            if (prdata !== readback)
                note_mismatch($sformatf("register %0d read expected %h got %h",
                                        idx, readback, prdata));
            psel    <= 1'b0;
            penable <= 1'b0;
        end
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // defaults after reset: magic 0, zero-length frame answered by ack then done
    task automatic test_reset_defaults();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h00);
        drain();
    endtask

    // no room at all: every body byte dropped, status flags the overflow;
    // noise before the header and a write past the register map change nothing
    task automatic test_dropped_payload();
        write_reg(REG_MAGIC, 32'h0000_00FF);
        write_reg(REG_ACK_TYPE, 32'h0000_00A5);
        write_reg(REG_BUF_LEN, 32'h0000_0000);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        send_byte(8'h00);
        send_byte(8'h7E);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h02);
        send_byte(8'h00);
        send_byte(8'hFF);   // body byte equal to magic is plain payload
        send_byte(8'h00);
        drain();
    endtask

    // frame exactly as long as the buffer: all stored, status ok
    task automatic test_exact_fit();
        write_reg(REG_BUF_LEN, 32'h0000_0002);
        send_byte(8'hFF);
        send_byte(8'h5A);
        send_byte(8'h02);
        send_byte(8'h00);
        send_byte(8'h81);
        send_byte(8'hFF);
        drain();
    endtask

    // registers rewritten between header and body act from the next byte on
    task automatic test_config_mid_frame();
        send_byte(8'hFF);
        send_byte(8'h3C);
        send_byte(8'h01);
        send_byte(8'h00);
        drain();
        write_reg(REG_ACK_TYPE, 32'h0000_00FF);
        write_reg(REG_BUF_LEN, 32'h0000_0000);
        send_byte(8'h80);
        drain();
    endtask

    // long frame across a chunk boundary while the receiver holds off,
    // so the command queue fills and the input stalls
    task automatic test_backpressure_long();
        write_reg(REG_MAGIC, $urandom_range(255, 0));
        write_reg(REG_ACK_TYPE, $urandom_range(255, 0));
        write_reg(REG_BUF_LEN, 32'd200);
        fork
            begin
                rx_hold = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold = 1'b0;
            end
        join_none
        send_frame(8'($urandom_range(255, 0)), 16'h0104);
        drain();
    endtask

    // well-formed frames with random content under changing settings,
    // some hunting noise in between
    task automatic test_random_frames();
        logic [7:0]  noise;
        logic [15:0] len;
        while (bytes_taken - bytes_ignored < BYTE_TARGET) begin
            if (bytes_taken - bytes_ignored >= CALM_AFTER) idle_on = 1'b0;
            case ($urandom_range(2, 0))
                0:       write_reg(REG_MAGIC, 32'h00);
                1:       write_reg(REG_MAGIC, 32'hFF);
                default: write_reg(REG_MAGIC, $urandom_range(255, 0));
            endcase
            write_reg(REG_ACK_TYPE, $urandom_range(255, 0));
            case ($urandom_range(3, 0))
                0:       write_reg(REG_BUF_LEN, 32'h0000);
                1:       write_reg(REG_BUF_LEN, 32'hFFFF);
                default: write_reg(REG_BUF_LEN, $urandom_range(12, 0));
            endcase
            repeat (3) begin
                if ($urandom_range(3, 0) == 0) begin
                    repeat ($urandom_range(3, 1)) begin
                        noise = 8'($urandom_range(255, 0));
                        if (noise == cfg_magic) noise = ~noise;
                        send_byte(noise);
                    end
                end
                if ($urandom_range(7, 0) == 0) len = 16'($urandom_range(40, 13));
                else len = 16'($urandom_range(12, 0));
                send_frame(8'($urandom_range(255, 0)), len);
            end
            drain();
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_dropped_payload();
        test_exact_fit();
        test_config_mid_frame();
        test_backpressure_long();
        test_random_frames();

        $display("covered %0d bytes in (%0d ignored while hunting), %0d result beats checked",
                 bytes_taken, bytes_ignored, beats_checked);
        $display("%0d frames finished, %0d over the buffer, input held off %0d cycles",
                 frames_done, frames_over, input_stalls);
        if (mismatches == 0 && beats_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #1000000;
        $display("timeout with %0d beats outstanding", beats_due.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/fmr_pkg.sv
rtl/fmr_front.sv
rtl/fmr_queue.sv
rtl/fmr_back.sv
rtl/framed_message_receiver.sv
bench/tb_framed_message_receiver.sv
